>>> hdl/pvr_pkg.sv
// Package for the phase vocoder bin resynthesis block: constants and CORDIC table.
`timescale 1ns / 1ps
package pvr_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ZW = 34;
    localparam int XW = 56;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                0: r = 34'sd536870912;
                1: r = 34'sd316933406;
                2: r = 34'sd167458907;
                3: r = 34'sd85004756;
                4: r = 34'sd42667331;
                5: r = 34'sd21354465;
                6: r = 34'sd10679838;
                7: r = 34'sd5340245;
                8: r = 34'sd2670163;
                9: r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                default: r = 34'sd20861;
            endcase
            return r;
        end
    endfunction
endpackage

>>> hdl/pvr_phase_store.sv
// Running phase store: blend, read-modify-write with forwarding, clearing pass.
`timescale 1ns / 1ps
module pvr_phase_store #(
    parameter int NUM_BINS = 1024,
    parameter int NUM_TRACKS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [15:0] mag_a,
    input  logic [15:0] mag_b,
    input  logic [15:0] dph_a,
    input  logic [15:0] dph_b,
    input  logic [15:0] blend,
    input  logic [9:0]  bin_in,
    input  logic        track_in,
    output logic        busy,
    output logic        out_valid,
    output logic [15:0] mag_out,
    output logic [15:0] phase_out,
    output logic [9:0]  bin_o,
    output logic        track_o
);
    localparam int DEPTH = NUM_BINS * NUM_TRACKS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0] mem [DEPTH];
    logic [AW:0] clr_reg;
    logic [AW-1:0] idx;
    logic [32:0] mag_sum, ph_sum;
    logic [16:0] finv;

    // stage 1 regs
    logic        v1_reg;
    logic [AW-1:0] a1_reg;
    logic [15:0] m1_reg, d1_reg, rd_reg;
    logic [9:0]  b1_reg;
    logic        t1_reg;
    // stage 2 (result)
    logic        v2_reg;
    logic [AW-1:0] a2_reg;
    logic [15:0] s2_reg, m2_reg;
    logic [9:0]  b2_reg;
    logic        t2_reg;

    logic [15:0] cur, sum;

    assign busy = !clr_reg[AW];
    assign idx = AW'((32'(track_in) % NUM_TRACKS) * NUM_BINS + (32'(bin_in) % NUM_BINS));
    assign finv = 17'd65536 - {1'b0, blend};
    assign mag_sum = 33'(mag_a) * 33'(finv) + 33'(mag_b) * 33'(blend) + 33'd32768;
    assign ph_sum = 33'(dph_a ^ 16'h8000) * 33'(finv)
                  + 33'(dph_b ^ 16'h8000) * 33'(blend) + 33'd32768;

    // forward a write to the same entry from the previous item
    assign cur = (v2_reg && a2_reg == a1_reg) ? s2_reg : rd_reg;
    assign sum = d1_reg + cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (busy) begin
            mem[clr_reg[AW-1:0]] <= 16'd0;
            clr_reg <= (clr_reg[AW-1:0] == AW'(DEPTH - 1)) ? {1'b1, {AW{1'b0}}}
                                                          : clr_reg + 1'b1;
        end else if (en) begin
            v1_reg <= in_valid;
            a1_reg <= idx;
            m1_reg <= mag_sum[31:16];
            d1_reg <= ph_sum[31:16] ^ 16'h8000;
            b1_reg <= bin_in;
            t1_reg <= track_in;
            rd_reg <= mem[idx];
            v2_reg <= v1_reg;
            a2_reg <= a1_reg;
            s2_reg <= sum;
            m2_reg <= m1_reg;
            b2_reg <= b1_reg;
            t2_reg <= t1_reg;
            if (v1_reg) mem[a1_reg] <= sum;
        end
    end

    // read in stage 1 may meet the write from stage 1 in the same cycle
    // when the next item hits the same entry: covered since stage 2 forwards.
    assign out_valid = v2_reg;
    assign mag_out = m2_reg;
    assign phase_out = s2_reg;
    assign bin_o = b2_reg;
    assign track_o = t2_reg;
endmodule

>>> hdl/pvr_cordic.sv
// Pipelined rotation CORDIC with quadrant fold and output rounding.
`timescale 1ns / 1ps
module pvr_cordic (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [15:0] mag,
    input  logic [15:0] phase,
    input  logic [9:0]  bin_in,
    input  logic        track_in,
    output logic        out_valid,
    output logic signed [17:0] re_out,
    output logic signed [17:0] im_out,
    output logic [9:0]  bin_o,
    output logic        track_o
);
    import pvr_pkg::*;
    localparam int N = CORDIC_STEPS;

    logic signed [XW-1:0] x_reg [N+1];
    logic signed [XW-1:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    logic        v_reg [N+2];
    logic [9:0]  b_reg [N+2];
    logic        t_reg [N+2];
    logic signed [17:0] re_reg, im_reg;

    logic signed [15:0] p, pf;
    logic signed [17:0] mf;
    logic fold;

    assign p = signed'(phase);
    assign fold = (p > 16'sd16384) || (p < -16'sd16384);
    assign pf = fold ? (p + 16'sh8000) : p;
    assign mf = fold ? -$signed({2'b00, mag}) : $signed({2'b00, mag});

    function automatic logic signed [17:0] rnd(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        begin
            r = (v + (XW'(1) <<< 29)) >>> 30;
            if (r > XW'(131071)) return 18'sd131071;
            if (r < -XW'(131072)) return -18'sd131072;
            return r[17:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N + 2; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < N + 2; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= XW'(mf) * XW'(INV_GAIN_Q30);
            y_reg[0] <= '0;
            z_reg[0] <= ZW'(pf) <<< 16;
            b_reg[0] <= bin_in;
            t_reg[0] <= track_in;
            for (int i = 0; i < N; i++) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_val(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_val(i);
                end
            end
            for (int i = 1; i < N + 2; i++) begin
                b_reg[i] <= b_reg[i-1];
                t_reg[i] <= t_reg[i-1];
            end
            re_reg <= rnd(x_reg[N]);
            im_reg <= rnd(y_reg[N]);
        end
    end

    assign out_valid = v_reg[N+1];
    assign re_out = re_reg;
    assign im_out = im_reg;
    assign bin_o = b_reg[N+1];
    assign track_o = t_reg[N+1];
endmodule

>>> hdl/phase_vocoder_bin_resynth.sv
// Top level of the phase vocoder bin resynthesis block.
//   channel | ports                                  | direction
//   input   | s_valid/s_ready, s_* bin fields        | in
//   result  | m_valid/m_ready, m_* rectangular bin   | out
// One item per cycle unless stalled or clearing; the path runs through
// blend, phase store RMW and a 16-stage CORDIC pipeline. A clearing pass
// after reset zeroes all NUM_BINS*NUM_TRACKS entries; s_ready is low meanwhile.
// The whole pipeline advances when the output register is empty or taken, so a stall holds all.
`timescale 1ns / 1ps
module phase_vocoder_bin_resynth #(
    parameter int NUM_BINS = 1024,
    parameter int NUM_TRACKS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_mag_this_frame,
    input  logic [15:0] s_mag_next_frame,
    input  logic signed [15:0] s_dphase_this_frame,
    input  logic signed [15:0] s_dphase_next_frame,
    input  logic [15:0] s_blend,
    input  logic [9:0]  s_bin_number,
    input  logic        s_track_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [17:0] m_real_part,
    output logic signed [17:0] m_imag_part,
    output logic [9:0]  m_bin_out,
    output logic        m_track_out
);
    logic en, busy, pv;
    logic [15:0] pmag, pph;
    logic [9:0] pbin;
    logic ptrk;

    assign en = !m_valid || m_ready;
    assign s_ready = en && !busy;

    pvr_phase_store #(.NUM_BINS(NUM_BINS), .NUM_TRACKS(NUM_TRACKS)) u_store (
        .aclk, .aresetn, .en,
        .in_valid(s_valid && s_ready),
        .mag_a(s_mag_this_frame), .mag_b(s_mag_next_frame),
        .dph_a(s_dphase_this_frame), .dph_b(s_dphase_next_frame),
        .blend(s_blend), .bin_in(s_bin_number), .track_in(s_track_number),
        .busy, .out_valid(pv), .mag_out(pmag), .phase_out(pph),
        .bin_o(pbin), .track_o(ptrk)
    );

    pvr_cordic u_cordic (
        .aclk, .aresetn, .en(en && !busy), .in_valid(pv), .mag(pmag), .phase(pph),
        .bin_in(pbin), .track_in(ptrk), .out_valid(m_valid),
        .re_out(m_real_part), .im_out(m_imag_part),
        .bin_o(m_bin_out), .track_o(m_track_out)
    );
endmodule

>>> bench/phase_vocoder_bin_resynth_checker.sv
// Checker for the bin resynthesis block: predicts each result and compares it.
`timescale 1ns / 1ps
module phase_vocoder_bin_resynth_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [15:0]        s_mag_this_frame,
    input  logic [15:0]        s_mag_next_frame,
    input  logic signed [15:0] s_dphase_this_frame,
    input  logic signed [15:0] s_dphase_next_frame,
    input  logic [15:0]        s_blend,
    input  logic [9:0]         s_bin_number,
    input  logic               s_track_number,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [17:0] m_real_part,
    input  logic signed [17:0] m_imag_part,
    input  logic [9:0]         m_bin_out,
    input  logic               m_track_out,
    output int                 fail_count,
    output int                 pending_bins,
    output int                 bins_seen
);
    localparam int BINS = 1024;
    localparam int TRACKS = 2;

    typedef struct packed {
        logic signed [17:0] re;
        logic signed [17:0] im;
        logic [9:0]         bin;
        logic               trk;
    } rect_bin_t;

    logic [15:0] phase_acc [BINS*TRACKS];
    rect_bin_t   rect_q [$];

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] f);
        logic [63:0] s;
        s = 64'(a) * (64'd65536 - 64'(f)) + 64'(b) * 64'(f) + 64'd32768;
        return s[31:16];
    endfunction

    function automatic logic signed [17:0] round_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    // rotate blended magnitude by phase p; updates nothing
    function automatic rect_bin_t rotate_bin(input logic [15:0] mag, input logic [15:0] ph);
        logic signed [63:0] x, y, z, m, xs, ys;
        logic signed [31:0] p;
        rect_bin_t r;
        p = 32'(signed'(ph));
        m = 64'(mag);
        if (p > 16384 || p < -16384) begin
            m = -m;
            p = 32'(signed'(16'(ph + 16'h8000)));
        end
        x = m * 64'sd652032874;
        y = 0;
        z = 64'(p) * 65536;
        for (int i = 0; i < pvr_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - 64'(pvr_pkg::atan_val(i));
            end else begin
                x = x + ys; y = y - xs; z = z + 64'(pvr_pkg::atan_val(i));
            end
        end
        r.re = round_out(x);
        r.im = round_out(y);
        r.bin = '0;
        r.trk = '0;
        return r;
    endfunction

    assign pending_bins = rect_q.size();

    always @(posedge aclk) begin
        logic [15:0] mag, dph, sum;
        int idx;
        rect_bin_t e;
        if (!aresetn) begin
            foreach (phase_acc[i]) phase_acc[i] = '0;
            rect_q.delete();
            fail_count <= 0;
            bins_seen <= 0;
        end else begin
            if (s_valid && s_ready) begin
                idx = int'(s_track_number) * BINS + int'(s_bin_number);
                mag = lerp16(s_mag_this_frame, s_mag_next_frame, s_blend);
                dph = lerp16(s_dphase_this_frame ^ 16'h8000, s_dphase_next_frame ^ 16'h8000,
                             s_blend) ^ 16'h8000;
                sum = dph + phase_acc[idx];
                phase_acc[idx] = sum;
                e = rotate_bin(mag, sum);
                e.bin = s_bin_number;
                e.trk = s_track_number;
                rect_q.push_back(e);
            end
            if (m_valid && m_ready) begin
                bins_seen <= bins_seen + 1;
                if (rect_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("mismatch: unexpected result re=%0d im=%0d bin=%0d",
                                 m_real_part, m_imag_part, m_bin_out);
                    fail_count <= fail_count + 1;
                end else begin
                    e = rect_q.pop_front();
                    if (e.re !== m_real_part || e.im !== m_imag_part
                        || e.bin !== m_bin_out || e.trk !== m_track_out) begin
                        if (fail_count < 10)
                            $display("mismatch: exp re=%0d im=%0d bin=%0d trk=%0d, ",
                                     e.re, e.im, e.bin, e.trk,
                                     "got re=%0d im=%0d bin=%0d trk=%0d",
                                     m_real_part, m_imag_part, m_bin_out, m_track_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/phase_vocoder_bin_resynth_test.sv
// Top of the bin resynthesis testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module phase_vocoder_bin_resynth_test;
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_mag_this_frame = '0;
    logic [15:0]        s_mag_next_frame = '0;
    logic signed [15:0] s_dphase_this_frame = '0;
    logic signed [15:0] s_dphase_next_frame = '0;
    logic [15:0]        s_blend = '0;
    logic [9:0]         s_bin_number = '0;
    logic               s_track_number = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [17:0] m_real_part, m_imag_part;
    logic [9:0]         m_bin_out;
    logic               m_track_out;
    int                 fail_count, pending_bins, bins_seen;
    int                 send_idle = 0, recv_stall = 0;
    int                 cycle_count = 0;
    int                 items_sent = 0;

    phase_vocoder_bin_resynth u_dut (.*);

    phase_vocoder_bin_resynth_checker u_check (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // run guard: clearing pass + 1710 items at worst stalls, many times over
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_bin(input logic [15:0] ma, input logic [15:0] mb,
                            input logic [15:0] pa, input logic [15:0] pb,
                            input logic [15:0] f, input logic [9:0] bin, input logic trk);
        // an idle cycle never leaves the previous item on the bus
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mag_this_frame <= ma;
        s_mag_next_frame <= mb;
        s_dphase_this_frame <= pa;
        s_dphase_next_frame <= pb;
        s_blend <= f;
        s_bin_number <= bin;
        s_track_number <= trk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drop_valid;
        s_valid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        logic [9:0] bin;
        for (int i = 0; i < n; i++) begin
            bin = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
            send_bin(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom), bin,
                     1'($urandom));
            if ($urandom_range(99) < send_idle) drop_valid();
        end
        drop_valid();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        m_ready <= 1'b1;
        // directed: field extremes, exact pi wrap, full blend, bin/track extremes
        send_bin(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h0000, 10'd1023, 1'b1);
        send_bin(16'hffff, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 10'd0, 1'b0);
        send_bin(16'h0000, 16'hffff, 16'h8000, 16'h8000, 16'hffff, 10'd0, 1'b0);
        send_bin(16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'h8000, 10'd5, 1'b0);
        send_bin(16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'h8000, 10'd5, 1'b0);
        send_bin(16'hffff, 16'hffff, 16'h4000, 16'h4000, 16'h0000, 10'd6, 1'b1);
        send_bin(16'hffff, 16'hffff, 16'hc000, 16'hc000, 16'h0000, 10'd7, 1'b1);
        send_bin(16'hffff, 16'hffff, 16'h4001, 16'h4001, 16'h0000, 10'd8, 1'b1);
        send_bin(16'h1234, 16'hfedc, 16'h8000, 16'h7fff, 16'h0001, 10'd512, 1'b0);
        send_bin(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1023, 1'b0);
        drop_valid();
        send_random(250);
        send_idle = 58;
        send_random(350);
        send_idle = 0; recv_stall = 58;
        send_random(350);
        send_idle = 37; recv_stall = 37;
        send_random(350);
        send_idle = 0; recv_stall = 0;
        send_random(400);
        recv_stall = 0;
        while (pending_bins != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("sent %0d bins, checked %0d results over five idling phases",
                 items_sent, bins_seen);
        if (fail_count == 0 && pending_bins == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
